// ----- hdl/rgb_to_yuv_frame_writer_top_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the RGB to YUV frame writer
// Shared concurrent assertion forms, clocked on the rising edge and disabled
// while the asynchronous reset is asserted.
// ----------------------------------------------------------------------------
`ifndef RGB_TO_YUV_FRAME_WRITER_TOP_DEFINES_SVH
`define RGB_TO_YUV_FRAME_WRITER_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RTYFW_ASSERT_SAME(lbl, clk_i, rst_n_i, ante, cons, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_n_i) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RTYFW_ASSERT_NEXT(lbl, clk_i, rst_n_i, ante, cons, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_n_i) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/rtyfw_pkg.sv -----
// ----------------------------------------------------------------------------
// RGB to YUV frame writer package
// Payload types, register indexes and fixed widths shared by all modules.
// ----------------------------------------------------------------------------
package rtyfw_pkg;

	localparam int OFF_W   = 25;
	localparam int CNT_W   = 12;
	localparam int IDX_W   = 24;
	localparam int CFG_W   = 13;
	localparam int CFG_IW  = 2;
	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = 2;

	localparam logic [CFG_IW-1:0] REG_OUTPUT_MODE  = 2'd0;
	localparam logic [CFG_IW-1:0] REG_FRAME_WIDTH  = 2'd1;
	localparam logic [CFG_IW-1:0] REG_FRAME_HEIGHT = 2'd2;

	localparam logic MODE_PACKED = 1'b0;
	localparam logic MODE_PLANAR = 1'b1;

	localparam logic [CFG_W-1:0] WIDTH_RESET  = 13'd640;
	localparam logic [CFG_W-1:0] HEIGHT_RESET = 13'd480;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rtyfw_pixel_t;

	typedef struct packed {
		logic [OFF_W-1:0] byte_offset;
		logic [7:0]       byte_value;
		logic             last_of_run;
	} rtyfw_out_t;

	// One pixel's worth of byte writes, up to four.
	typedef struct packed {
		logic [1:0]                  last_idx;
		logic [3:0][OFF_W-1:0]       off;
		logic [3:0][7:0]             val;
	} rtyfw_entry_t;

endpackage

// ----- hdl/rtyfw_front.sv -----
// ----------------------------------------------------------------------------
// RGB to YUV frame writer front end
// Accepts pixels, tracks raster position, converts color and forms the
// byte-write group that each pixel causes.
// ----------------------------------------------------------------------------
module rtyfw_front #(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  rtyfw_pkg::rtyfw_pixel_t           in_data,
	input  logic                              cfg_we,
	input  logic [rtyfw_pkg::CFG_IW-1:0]      cfg_index,
	input  logic [rtyfw_pkg::CFG_W-1:0]       cfg_wdata,
	output logic                              push_valid,
	input  logic                              push_ready,
	output rtyfw_pkg::rtyfw_entry_t           push_data
);
	import rtyfw_pkg::*;

	localparam int WW   = $clog2(MAX_WIDTH + 1);
	localparam int HW   = $clog2(MAX_HEIGHT + 1);
	localparam int RW_W = CNT_W + WW;
	localparam int AR_W = WW + HW;

	function automatic logic [7:0] calc_y(input rtyfw_pixel_t p);
		logic [15:0] s;
		s = 16'(p.red) * 16'd66 + 16'(p.green) * 16'd129 + 16'(p.blue) * 16'd25 + 16'd128;
		return s[15:8] + 8'd16;
	endfunction

	// The bias of 128*256 keeps the sum positive, so bits 15:8 already carry the offset.
	function automatic logic [7:0] calc_u(input rtyfw_pixel_t p);
		logic [16:0] s;
		s = 17'd32896 + 17'(p.blue) * 17'd112 - 17'(p.red) * 17'd38 - 17'(p.green) * 17'd74;
		return s[15:8];
	endfunction

	function automatic logic [7:0] calc_v(input rtyfw_pixel_t p);
		logic [16:0] s;
		s = 17'd32896 + 17'(p.red) * 17'd112 - 17'(p.green) * 17'd94 - 17'(p.blue) * 17'd18;
		return s[15:8];
	endfunction

	logic             mode_q;
	logic [CFG_W-1:0] fw_q;
	logic [CFG_W-1:0] fh_q;
	logic [WW-1:0]    w;
	logic [HW-1:0]    h;

	logic [CNT_W-1:0] col_q;
	logic [CNT_W-1:0] row_q;
	logic             phase_q;
	logic [IDX_W-1:0] pidx_q;
	logic             col_wrap;
	logic             row_wrap;
	logic             accept;

	logic             s1_v;
	rtyfw_pixel_t     pix_s1;
	logic             mode_s1;
	logic             phase_s1;
	logic [CNT_W-1:0] col_s1;
	logic [CNT_W-1:0] row_s1;
	logic [IDX_W-1:0] base_s1;

	logic             s2_v;
	logic             mode_s2;
	logic             phase_s2;
	logic [CNT_W-1:0] col_s2;
	logic             row0_s2;
	logic [IDX_W-1:0] base_s2;
	logic [7:0]       y_s2;
	logic [7:0]       u_s2;
	logic [7:0]       v_s2;
	logic [RW_W-1:0]  prod_rw_s2;
	logic [RW_W-1:0]  prod_uv_s2;

	logic [7:0]       held_y_q;
	logic [7:0]       held_u_q;
	logic [7:0]       held_v_q;

	logic [AR_W-1:0]  area_q;
	logic [OFF_W-1:0] area54_q;

	logic             s1_adv;
	logic             s2_done;
	logic [7:0]       y_c;
	logic [7:0]       u_c;
	logic [7:0]       v_c;
	logic [OFF_W-1:0] uvc;
	logic [OFF_W-1:0] base2;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_PACKED;
			fw_q   <= WIDTH_RESET;
			fh_q   <= HEIGHT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_OUTPUT_MODE:  mode_q <= cfg_wdata[0];
				REG_FRAME_WIDTH:  fw_q   <= cfg_wdata;
				REG_FRAME_HEIGHT: fh_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (fw_q < CFG_W'(2))
			w = WW'(2);
		else if (int'(fw_q) > MAX_WIDTH)
			w = WW'(MAX_WIDTH);
		else
			w = WW'(fw_q);
		if (fh_q < CFG_W'(2))
			h = HW'(2);
		else if (int'(fh_q) > MAX_HEIGHT)
			h = HW'(MAX_HEIGHT);
		else
			h = HW'(fh_q);
	end

	// Frame area and the start of the V plane only change with configuration.
	always_ff @(posedge clk) begin
		area_q   <= AR_W'(w) * AR_W'(h);
		area54_q <= OFF_W'(area_q) + OFF_W'(area_q >> 2);
	end

	// Pipeline flow: an even packed pixel leaves stage two without a push.
	assign push_valid = s2_v && (mode_s2 == MODE_PLANAR || phase_s2);
	assign s2_done    = !push_valid || push_ready;
	assign s1_adv     = s1_v && (!s2_v || s2_done);
	assign in_ready   = !s1_v || s1_adv;
	assign accept     = in_valid && in_ready;

	assign col_wrap = ({1'b0, col_q} + (CNT_W + 1)'(1)) >= w;
	assign row_wrap = ({1'b0, row_q} + (CNT_W + 1)'(1)) >= h;

	// Raster position, advanced at each accepted pixel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			phase_q <= 1'b0;
			pidx_q  <= '0;
		end else if (accept) begin
			if (col_wrap) begin
				col_q <= '0;
				if (row_wrap) begin
					row_q   <= '0;
					pidx_q  <= '0;
					phase_q <= 1'b0;
				end else begin
					row_q   <= row_q + CNT_W'(1);
					pidx_q  <= pidx_q + IDX_W'(1);
					phase_q <= !phase_q;
				end
			end else begin
				col_q   <= col_q + CNT_W'(1);
				pidx_q  <= pidx_q + IDX_W'(1);
				phase_q <= !phase_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v <= 1'b0;
			s2_v <= 1'b0;
		end else begin
			if (in_ready)
				s1_v <= in_valid;
			if (!s2_v || s2_done)
				s2_v <= s1_adv;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1   <= in_data;
			mode_s1  <= mode_q;
			phase_s1 <= phase_q;
			col_s1   <= col_q;
			row_s1   <= row_q;
			base_s1  <= pidx_q - IDX_W'(1);
		end
	end

	assign y_c = calc_y(pix_s1);
	assign u_c = calc_u(pix_s1);
	assign v_c = calc_v(pix_s1);

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			mode_s2    <= mode_s1;
			phase_s2   <= phase_s1;
			col_s2     <= col_s1;
			row0_s2    <= row_s1[0];
			base_s2    <= base_s1;
			y_s2       <= y_c;
			u_s2       <= u_c;
			v_s2       <= v_c;
			prod_rw_s2 <= RW_W'(row_s1) * RW_W'(w);
			prod_uv_s2 <= RW_W'(row_s1 >> 1) * RW_W'(w >> 1);
		end
	end

	// The even pixel of a packed pair is held for its odd partner.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_y_q <= '0;
			held_u_q <= '0;
			held_v_q <= '0;
		end else if (s1_adv && mode_s1 == MODE_PACKED && !phase_s1) begin
			held_y_q <= y_c;
			held_u_q <= u_c;
			held_v_q <= v_c;
		end
	end

	assign uvc   = OFF_W'(prod_uv_s2) + OFF_W'(col_s2 >> 1);
	assign base2 = {base_s2, 1'b0};

	always_comb begin
		push_data = '0;
		if (mode_s2 == MODE_PACKED) begin
			push_data.last_idx = 2'd3;
			push_data.off[0]   = base2;
			push_data.off[1]   = base2 + OFF_W'(1);
			push_data.off[2]   = base2 + OFF_W'(2);
			push_data.off[3]   = base2 + OFF_W'(3);
			push_data.val[0]   = held_y_q;
			push_data.val[1]   = held_u_q;
			push_data.val[2]   = y_s2;
			push_data.val[3]   = held_v_q;
		end else begin
			push_data.last_idx = (!row0_s2 && !col_s2[0]) ? 2'd2 : 2'd0;
			push_data.off[0]   = OFF_W'(prod_rw_s2) + OFF_W'(col_s2);
			push_data.off[1]   = OFF_W'(area_q) + uvc;
			push_data.off[2]   = area54_q + uvc;
			push_data.val[0]   = y_s2;
			push_data.val[1]   = u_s2;
			push_data.val[2]   = v_s2;
		end
	end

endmodule

// ----- hdl/rtyfw_queue.sv -----
// ----------------------------------------------------------------------------
// RGB to YUV frame writer group queue
// Short FIFO of byte-write groups between the front end and the writer.
// ----------------------------------------------------------------------------
module rtyfw_queue (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push_valid,
	output logic                    push_ready,
	input  rtyfw_pkg::rtyfw_entry_t push_data,
	output logic                    head_valid,
	output rtyfw_pkg::rtyfw_entry_t head_data,
	input  logic                    pop
);
	import rtyfw_pkg::*;

	rtyfw_entry_t    mem_q [Q_DEPTH];
	logic [Q_AW-1:0] wr_ptr_q;
	logic [Q_AW-1:0] rd_ptr_q;
	logic [Q_AW:0]   count_q;
	logic            push;
	logic            do_pop;

	assign push_ready = count_q != (Q_AW + 1)'(Q_DEPTH);
	assign head_valid = count_q != '0;
	assign head_data  = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + Q_AW'(1);
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + Q_AW'(1);
			if (push && !do_pop)
				count_q <= count_q + (Q_AW + 1)'(1);
			else if (do_pop && !push)
				count_q <= count_q - (Q_AW + 1)'(1);
		end
	end

endmodule

// ----- hdl/rtyfw_back.sv -----
// ----------------------------------------------------------------------------
// RGB to YUV frame writer back end
// Walks each queued group and presents one byte write per transfer.
// ----------------------------------------------------------------------------
module rtyfw_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    head_valid,
	input  rtyfw_pkg::rtyfw_entry_t head_data,
	output logic                    pop,
	output logic                    out_valid,
	input  logic                    out_ready,
	output rtyfw_pkg::rtyfw_out_t   out_data
);
	import rtyfw_pkg::*;

	logic       out_valid_q;
	rtyfw_out_t out_q;
	logic [1:0] k_q;
	logic       load;
	logic       last;

	assign load      = head_valid && (!out_valid_q || out_ready);
	assign last      = k_q == head_data.last_idx;
	assign pop       = load && last;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			k_q         <= '0;
		end else begin
			if (load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			if (load)
				k_q <= last ? 2'd0 : k_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q.byte_offset <= head_data.off[k_q];
			out_q.byte_value  <= head_data.val[k_q];
			out_q.last_of_run <= last;
		end
	end

endmodule

// ----- hdl/rgb_to_yuv_frame_writer_top.sv -----
// ----------------------------------------------------------------------------
// RGB to YUV frame writer
// Converts a raster RGB pixel stream to BT.601 byte writes into a frame buffer.
//
// Pixels enter on in_valid/in_ready; each transfer on out_valid/out_ready is
// one byte write (offset, value, last byte of its pixel). Packed YUYV mode
// writes four bytes per odd pixel and none for even ones; planar 4:2:0 mode
// writes Y for every pixel plus U and V on even rows and columns.
// A pixel's first byte passes the stage-one and stage-two registers, a queue
// entry and the output register. The writer stage delivers one byte per cycle
// while the receiver is ready; the front end takes a pixel every cycle while
// its four-entry group queue has room. Configuration is written through
// cfg_we/cfg_index/cfg_wdata; the user must write it only while idle, which
// the block does not enforce. Reset clears the raster position and loads
// packed mode at 640 by 480. When the receiver stalls, the output byte holds,
// the queue fills and in_ready falls; no byte is lost or repeated.
// ----------------------------------------------------------------------------
module rgb_to_yuv_frame_writer_top #(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  rtyfw_pkg::rtyfw_pixel_t      in_data,
	output logic                         out_valid,
	input  logic                         out_ready,
	output rtyfw_pkg::rtyfw_out_t        out_data,
	input  logic                         cfg_we,
	input  logic [rtyfw_pkg::CFG_IW-1:0] cfg_index,
	input  logic [rtyfw_pkg::CFG_W-1:0]  cfg_wdata
);
	import rtyfw_pkg::*;

	logic         push_valid;
	logic         push_ready;
	rtyfw_entry_t push_data;
	logic         head_valid;
	rtyfw_entry_t head_data;
	logic         pop;

	rtyfw_front #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data (push_data)
	);

	rtyfw_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data (push_data),
		.head_valid(head_valid),
		.head_data (head_data),
		.pop       (pop)
	);

	rtyfw_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(head_valid),
		.head_data (head_data),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

// ----- hdl/rtyfw_checker.sv -----
// ----------------------------------------------------------------------------
// RGB to YUV frame writer port checker
// Watches the top-level ports and flags output behavior that cannot occur.
// ----------------------------------------------------------------------------
`include "rgb_to_yuv_frame_writer_top_defines.svh"

module rtyfw_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input rtyfw_pkg::rtyfw_pixel_t      in_data,
	input logic                         out_valid,
	input logic                         out_ready,
	input rtyfw_pkg::rtyfw_out_t        out_data
);
	import rtyfw_pkg::*;

	// A pixel offered but not taken must stay offered unchanged.
	`RTYFW_ASSERT_NEXT(a_in_hold, clk, arst_n, in_valid && !in_ready,
		in_valid && $stable(in_data), "stalled input transfer changed")

	// A stalled byte write must stay offered unchanged.
	`RTYFW_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(out_data), "stalled output transfer changed")

	// Every luma and chroma byte lies in the studio range.
	`RTYFW_ASSERT_SAME(a_value_range, clk, arst_n, out_valid,
		out_data.byte_value >= 8'd16 && out_data.byte_value <= 8'd240,
		"byte value outside 16..240")

	// Nothing can be offered in the first cycle after reset is released.
	`RTYFW_ASSERT_SAME(a_reset_empty, clk, arst_n, $rose(arst_n), !out_valid,
		"output valid right after reset")

endmodule

bind rgb_to_yuv_frame_writer_top rtyfw_checker u_checker (.*);

// ----- tb/rgb_to_yuv_frame_writer_top_test.sv -----
// ----------------------------------------------------------------------------
// RGB to YUV frame writer testbench
// Streams RGB pixels through the writer under changing frame sizes and output
// modes, predicts every byte write with an independent BT.601 converter and
// checks each transfer on the output channel, field by field, in order.
// ----------------------------------------------------------------------------
module rgb_to_yuv_frame_writer_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	import rtyfw_pkg::*;

	localparam int FRAME_MAX_W   = 4096;
	localparam int FRAME_MAX_H   = 4096;
	localparam int RESET_CYCLES  = 8;
	localparam int DRAIN_CYCLES  = 16;
	localparam int MAX_PAUSE     = 20;
	localparam int MAX_REPORTS   = 50;
	localparam int IDLE_LOW      = 12;
	localparam int IDLE_HIGH     = 66;
	localparam int PHASES        = 4;
	localparam int TIMEOUT_NS    = 2_000_000;

	// The register file decodes two index bits; this one is not mapped.
	localparam logic [CFG_IW-1:0] REG_UNUSED = 2'd3;

	typedef enum logic {ROW_PIXEL, ROW_WRITE} row_kind_t;

	typedef struct packed {
		row_kind_t         kind;
		logic              known;
		logic [2:0]        n_known;
		logic [CFG_IW-1:0] reg_index;
		logic [CFG_W-1:0]  reg_value;
		rtyfw_pixel_t      px;
		rtyfw_out_t [3:0]  known_bytes;
	} stim_row_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_ready;
	rtyfw_pixel_t     in_data = '0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	rtyfw_out_t       out_data;
	logic             cfg_we = 1'b0;
	logic [CFG_IW-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_wdata = '0;

	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	int unsigned mismatches = 0;

	rtyfw_out_t pending_writes [$];
	stim_row_t  known_plan [$];
	stim_row_t  dir_rows [$];

	// Converter state, mirrored from the block.
	logic             cur_mode = MODE_PACKED;
	logic [CFG_W-1:0] cur_width = WIDTH_RESET;
	logic [CFG_W-1:0] cur_height = HEIGHT_RESET;
	logic [CNT_W-1:0] col_pos = '0;
	logic [CNT_W-1:0] row_pos = '0;
	logic             odd_next = 1'b0;
	logic [IDX_W-1:0] pix_idx = '0;
	logic [7:0]       hold_y = '0;
	logic [7:0]       hold_u = '0;
	logic [7:0]       hold_v = '0;

	rgb_to_yuv_frame_writer_top #(
		.MAX_WIDTH(FRAME_MAX_W),
		.MAX_HEIGHT(FRAME_MAX_H)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always #4 clk = ~clk;

	function automatic rtyfw_out_t make_write(input logic [31:0] off, input logic [7:0] val,
			input logic last);
		rtyfw_out_t w;
		w.byte_offset = off[OFF_W-1:0];
		w.byte_value = val;
		w.last_of_run = last;
		return w;
	endfunction

	function automatic int clamp_size(input logic [CFG_W-1:0] raw, input int hi);
		if (raw < 2) return 2;
		if (int'(raw) > hi) return hi;
		return int'(raw);
	endfunction

	function automatic logic [7:0] luma_of(input int r, input int g, input int b);
		return 8'(((66 * r + 129 * g + 25 * b + 128) >>> 8) + 16);
	endfunction

	// The 128 * 256 bias keeps the sum positive, so the shift floors correctly.
	function automatic logic [7:0] blue_diff(input int r, input int g, input int b);
		return 8'((-38 * r - 74 * g + 112 * b + 128 + 32768) >>> 8);
	endfunction

	function automatic logic [7:0] red_diff(input int r, input int g, input int b);
		return 8'((112 * r - 94 * g - 18 * b + 128 + 32768) >>> 8);
	endfunction

	function automatic int convert_pixel(input rtyfw_pixel_t px, output rtyfw_out_t [3:0] res);
		int r, g, b, w, h, col, row, area, uv, n;
		logic [7:0] luma;
		logic [IDX_W-1:0] prev;
		logic [31:0] base;
		logic chroma;
		r = int'(px.red);
		g = int'(px.green);
		b = int'(px.blue);
		w = clamp_size(cur_width, FRAME_MAX_W);
		h = clamp_size(cur_height, FRAME_MAX_H);
		luma = luma_of(r, g, b);
		res = '0;
		n = 0;
		if (cur_mode == MODE_PACKED) begin
			if (!odd_next) begin
				hold_y = luma;
				hold_u = blue_diff(r, g, b);
				hold_v = red_diff(r, g, b);
			end else begin
				prev = pix_idx - 1'b1;
				base = {7'd0, prev, 1'b0};
				res[0] = make_write(base, hold_y, 1'b0);
				res[1] = make_write(base + 1, hold_u, 1'b0);
				res[2] = make_write(base + 2, luma, 1'b0);
				res[3] = make_write(base + 3, hold_v, 1'b1);
				n = 4;
			end
		end else begin
			col = int'(col_pos);
			row = int'(row_pos);
			area = w * h;
			chroma = (row % 2 == 0) && (col % 2 == 0);
			res[0] = make_write(row * w + col, luma, !chroma);
			n = 1;
			if (chroma) begin
				uv = (row / 2) * (w / 2) + col / 2;
				res[1] = make_write(area + uv, blue_diff(r, g, b), 1'b0);
				res[2] = make_write(area + area / 4 + uv, red_diff(r, g, b), 1'b1);
				n = 3;
			end
		end

		// Raster advance; a position already past a shrunken frame wraps here.
		odd_next = !odd_next;
		pix_idx = pix_idx + 1'b1;
		if (int'(col_pos) + 1 >= w) begin
			col_pos = '0;
			if (int'(row_pos) + 1 >= h) begin
				row_pos = '0;
				pix_idx = '0;
				odd_next = 1'b0;
			end else begin
				row_pos = row_pos + 1'b1;
			end
		end else begin
			col_pos = col_pos + 1'b1;
		end
		return n;
	endfunction

	function automatic void apply_reg(input logic [CFG_IW-1:0] idx,
			input logic [CFG_W-1:0] data);
		case (idx)
			REG_OUTPUT_MODE: begin
				cur_mode = data[0];
			end
			REG_FRAME_WIDTH: begin
				cur_width = data;
			end
			REG_FRAME_HEIGHT: begin
				cur_height = data;
			end
			default: begin
			end
		endcase
	endfunction

	task automatic report_mismatch(input string what);
		mismatches++;
		if (mismatches <= MAX_REPORTS) begin
			$display("%0t ns: %s", $realtime, what);
		end
	endtask

	task automatic take_pixel(input rtyfw_pixel_t px);
		stim_row_t plan;
		rtyfw_out_t [3:0] res;
		int n;
		int k;
		n = convert_pixel(px, res);
		if (known_plan.size() != 0) begin
			plan = known_plan.pop_front();
			if (plan.known) begin
				n = plan.n_known;
				res = plan.known_bytes;
			end
		end
		for (k = 0; k < n; k++) begin
			pending_writes.push_back(res[k]);
		end
	endtask

	task automatic check_write(input rtyfw_out_t got);
		rtyfw_out_t want;
		if (pending_writes.size() == 0) begin
			report_mismatch($sformatf("unexpected byte write at offset 0x%0h value 0x%0h",
				got.byte_offset, got.byte_value));
			return;
		end
		want = pending_writes.pop_front();
		if (got.byte_offset !== want.byte_offset) begin
			report_mismatch($sformatf("byte_offset 0x%0h, expected 0x%0h",
				got.byte_offset, want.byte_offset));
		end
		if (got.byte_value !== want.byte_value) begin
			report_mismatch($sformatf("byte_value 0x%0h at offset 0x%0h, expected 0x%0h",
				got.byte_value, want.byte_offset, want.byte_value));
		end
		if (got.last_of_run !== want.last_of_run) begin
			report_mismatch($sformatf("last_of_run %b at offset 0x%0h, expected %b",
				got.last_of_run, want.byte_offset, want.last_of_run));
		end
	endtask

	// All sampling uses the values from before the edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we) begin
				apply_reg(cfg_index, cfg_wdata);
			end
			if (in_valid && in_ready) begin
				take_pixel(in_data);
			end
			if (out_valid && out_ready) begin
				check_write(out_data);
			end
		end
	end

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	function automatic stim_row_t pixel_known(input logic [7:0] r, g, b, input int nbytes,
			input int base, input logic [7:0] y0, cb, y1, cr);
		stim_row_t row;
		row = '0;
		row.kind = ROW_PIXEL;
		row.px = '{red: r, green: g, blue: b};
		row.known = 1'b1;
		row.n_known = 3'(nbytes);
		row.known_bytes[0] = make_write(base, y0, 1'b0);
		row.known_bytes[1] = make_write(base + 1, cb, 1'b0);
		row.known_bytes[2] = make_write(base + 2, y1, 1'b0);
		row.known_bytes[3] = make_write(base + 3, cr, 1'b1);
		return row;
	endfunction

	function automatic stim_row_t pixel_row(input logic [7:0] r, g, b);
		stim_row_t row;
		row = '0;
		row.kind = ROW_PIXEL;
		row.px = '{red: r, green: g, blue: b};
		return row;
	endfunction

	function automatic stim_row_t reg_row(input logic [CFG_IW-1:0] idx,
			input logic [CFG_W-1:0] value);
		stim_row_t row;
		row = '0;
		row.kind = ROW_WRITE;
		row.reg_index = idx;
		row.reg_value = value;
		return row;
	endfunction

	function automatic logic [7:0] rand_channel();
		if ($urandom_range(6) == 0) begin
			return $urandom_range(1) ? 8'hFF : 8'h00;
		end
		return 8'($urandom);
	endfunction

	// Mostly tiny frames so that row and frame wrap come often.
	function automatic logic [CFG_W-1:0] pick_dim();
		case ($urandom_range(11))
			0: begin
				return CFG_W'($urandom_range(1));
			end
			1: begin
				return CFG_W'($urandom_range(8191, 4096));
			end
			2: begin
				return CFG_W'($urandom_range(64, 2));
			end
			default: begin
				return CFG_W'($urandom_range(7, 2));
			end
		endcase
	endfunction

	// Leaves valid high after the transfer; the next call or settle() decides.
	task automatic send_pixel(input stim_row_t row);
		int unsigned pause;
		pause = 0;
		while (pause < MAX_PAUSE && $urandom_range(99) < send_idle_pct) begin
			pause++;
		end
		cfg_we <= 1'b0;
		known_plan.push_back(row);
		if (pause > 0) begin
			in_valid <= 1'b0;
			repeat (pause) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= row.px;
		@(posedge clk);
		while (!in_ready) begin
			@(posedge clk);
		end
	endtask

	// An even packed pixel produces nothing, so it may still be in flight when
	// the queue runs dry; the extra cycles cover it.
	task automatic settle();
		in_valid <= 1'b0;
		cfg_we <= 1'b0;
		@(posedge clk);
		while (pending_writes.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
	endtask

	task automatic run_phase(input int unsigned npix);
		settle();
		write_reg(REG_OUTPUT_MODE,
			CFG_W'($urandom_range(1) ? MODE_PLANAR : MODE_PACKED));
		if ($urandom_range(9) < 7) begin
			write_reg(REG_FRAME_WIDTH, pick_dim());
		end
		if ($urandom_range(9) < 7) begin
			write_reg(REG_FRAME_HEIGHT, pick_dim());
		end
		if ($urandom_range(19) == 0) begin
			write_reg(REG_UNUSED, CFG_W'($urandom));
		end
		repeat (npix) send_pixel(pixel_row(rand_channel(), rand_channel(), rand_channel()));
	endtask

	initial begin
		int regime;
		bit busy;
		busy = 1'b0;

		// Packed mode from reset: pairs land at consecutive offsets, chroma
		// from the even pixel of each pair.
		dir_rows = '{
			pixel_known(8'd0, 8'd0, 8'd0, 0, 0, 8'd0, 8'd0, 8'd0, 8'd0),
			pixel_known(8'd255, 8'd255, 8'd255, 4, 0, 8'd16, 8'd128, 8'd235, 8'd128),
			pixel_known(8'd255, 8'd0, 8'd0, 0, 0, 8'd0, 8'd0, 8'd0, 8'd0),
			pixel_known(8'd0, 8'd0, 8'd255, 4, 4, 8'd82, 8'd90, 8'd41, 8'd240),
			pixel_known(8'd0, 8'd0, 8'd255, 0, 0, 8'd0, 8'd0, 8'd0, 8'd0),
			pixel_known(8'd0, 8'd255, 8'd0, 4, 8, 8'd41, 8'd240, 8'd144, 8'd110),
			// Sizes below the range saturate to two; the column wraps at once.
			reg_row(REG_FRAME_WIDTH, 13'd1),
			reg_row(REG_FRAME_HEIGHT, 13'd0),
			reg_row(REG_UNUSED, 13'h1FFF),
			pixel_row(8'd200, 8'd100, 8'd50),
			pixel_row(8'd17, 8'd240, 8'd129),
			pixel_row(8'd255, 8'd255, 8'd0),
			// Planar with an odd pixel count per frame.
			reg_row(REG_OUTPUT_MODE, CFG_W'(MODE_PLANAR)),
			reg_row(REG_FRAME_WIDTH, 13'd3),
			reg_row(REG_FRAME_HEIGHT, 13'd3),
			pixel_row(8'd255, 8'd0, 8'd255),
			pixel_row(8'd0, 8'd255, 8'd255),
			pixel_row(8'd128, 8'd128, 8'd128),
			pixel_row(8'd1, 8'd254, 8'd85),
			pixel_row(8'd170, 8'd85, 8'd1),
			// Back to packed in the middle of the frame.
			reg_row(REG_OUTPUT_MODE, CFG_W'(MODE_PACKED)),
			pixel_row(8'd12, 8'd34, 8'd56),
			pixel_row(8'd255, 8'd128, 8'd0),
			pixel_row(8'd0, 8'd128, 8'd255),
			pixel_row(8'd99, 8'd0, 8'd201),
			pixel_row(8'd7, 8'd7, 8'd7),
			// Oversized values saturate to the largest frame.
			reg_row(REG_FRAME_WIDTH, 13'd8191),
			reg_row(REG_FRAME_HEIGHT, 13'd4097),
			reg_row(REG_OUTPUT_MODE, CFG_W'(MODE_PLANAR)),
			pixel_row(8'd90, 8'd180, 8'd45),
			pixel_row(8'd255, 8'd255, 8'd255)
		};

		send_idle_pct = IDLE_LOW;
		recv_idle_pct = IDLE_HIGH;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_WRITE) begin
				if (busy) begin
					settle();
					busy = 1'b0;
				end
				write_reg(dir_rows[i].reg_index, dir_rows[i].reg_value);
			end else begin
				send_pixel(dir_rows[i]);
				busy = 1'b1;
			end
		end

		for (regime = 0; regime < 3; regime++) begin
			case (regime)
				0: begin
					send_idle_pct = IDLE_LOW;
					recv_idle_pct = IDLE_HIGH;
				end
				1: begin
					send_idle_pct = IDLE_HIGH;
					recv_idle_pct = IDLE_LOW;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			repeat (PHASES) run_phase($urandom_range(26, 14));
		end

		settle();
		if (mismatches == 0) begin
			$display("rgb_to_yuv_frame_writer_top: match");
		end else begin
			$display("rgb_to_yuv_frame_writer_top: mismatch");
		end
		$finish;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("rgb_to_yuv_frame_writer_top: mismatch");
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/rtyfw_pkg.sv
hdl/rtyfw_front.sv
hdl/rtyfw_queue.sv
hdl/rtyfw_back.sv
hdl/rgb_to_yuv_frame_writer_top.sv
hdl/rtyfw_checker.sv
tb/rgb_to_yuv_frame_writer_top_test.sv
